// File: hdl/mciir_pkg.sv
// ----------------------------------------------------------------------------
// mciir_pkg
// Shared types and constants of the multichannel IIR filter: item layouts,
// request and register codes, and the controller-to-datapath buses.
// ----------------------------------------------------------------------------
package mciir_pkg;

    localparam int SW        = 24;           // sample width, Q1.23
    localparam int CW        = 32;           // coefficient width, Q4.28
    localparam int PRODW     = SW + CW;      // exact product width
    localparam int ACCW      = 64;           // accumulator width
    localparam int FRAC      = CW - 4;       // fraction bits dropped at rounding
    localparam int CHAN_W    = 3;
    localparam int CIDX_W    = 4;
    localparam int NCOEF     = 2 ** CIDX_W;  // coefficient slots reachable by an index
    localparam int TAPS_W    = 5;
    localparam int NCH_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // request types
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_FF_WR  = 2'd1;
    localparam logic [1:0] REQ_FB_WR  = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FF_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_TAPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CH  = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [CHAN_W-1:0]        channel;
        logic signed [SW-1:0]     sample;
        logic [CIDX_W-1:0]        coeff_index;
        logic signed [CW-1:0]     coeff_value;
    } t_req_item;

    typedef struct packed {
        logic [CHAN_W-1:0]        out_channel;
        logic signed [SW-1:0]     filtered_sample;
        logic                     saturated;
    } t_res_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_DAT_W-1:0]     wr_data;
    } t_cfg_item;

    typedef struct packed {
        logic                     take;      // latch a sample request
        logic                     ff_wr;     // write one feedforward coefficient
        logic                     fb_wr;     // write one feedback coefficient
        logic                     clear;     // drop all channel history
        logic                     issue_ff;  // fetch operands of feedforward tap
        logic                     issue_fb;  // fetch operands of feedback tap
        logic [TAPS_W-1:0]        tap;
        logic                     done;      // load result, push history
    } t_cmd;

    typedef struct packed {
        logic                     sample_ok;
        logic [TAPS_W-1:0]        nff;
        logic [TAPS_W-1:0]        nfb;
        logic                     pipe_busy;
        logic                     out_free;
    } t_sts;

endpackage

// File: hdl/mciir_stream_if.sv
// ----------------------------------------------------------------------------
// mciir_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface mciir_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/mciir_ctrl.sv
// ----------------------------------------------------------------------------
// mciir_ctrl
// Request sequencer: decodes requests, steps the tap loop and closes a sample.
// ----------------------------------------------------------------------------
module mciir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [1:0]        i_req_type,
    output logic              o_req_ready,
    input  mciir_pkg::t_sts   i_sts,
    output mciir_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FF    = 5'b00010,
        S_FB    = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [mciir_pkg::TAPS_W-1:0]    r_tap, n_tap;
    logic                            take;

    assign o_req_ready = (r_state == S_IDLE);
    assign take        = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        o_cmd.tap = r_tap;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_req_type)
                        mciir_pkg::REQ_FF_WR: o_cmd.ff_wr = 1'b1;
                        mciir_pkg::REQ_FB_WR: o_cmd.fb_wr = 1'b1;
                        mciir_pkg::REQ_CLEAR: o_cmd.clear = 1'b1;
                        default: begin
                            // sample on a channel not in use: drop it
                            if (i_sts.sample_ok) begin
                                o_cmd.take = 1'b1;
                                n_tap      = '0;
                                if (i_sts.nff != '0)
                                    n_state = S_FF;
                                else if (i_sts.nfb != '0)
                                    n_state = S_FB;
                                else
                                    n_state = S_DRAIN;
                            end
                        end
                    endcase
                end
            end
            S_FF: begin
                o_cmd.issue_ff = 1'b1;
                if (r_tap == i_sts.nff - 1'b1) begin
                    n_tap   = '0;
                    n_state = (i_sts.nfb != '0) ? S_FB : S_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_FB: begin
                o_cmd.issue_fb = 1'b1;
                if (r_tap == i_sts.nfb - 1'b1) begin
                    n_tap   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy)
                    n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

endmodule

// File: hdl/mciir_mac.sv
// ----------------------------------------------------------------------------
// mciir_mac
// Shared multiply-accumulate with round-half-up and saturation to Q1.23.
// ----------------------------------------------------------------------------
module mciir_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_valid,
    input  logic signed [mciir_pkg::SW-1:0]   i_op,
    input  logic signed [mciir_pkg::CW-1:0]   i_coef,
    output logic                              o_busy,
    output logic signed [mciir_pkg::SW-1:0]   o_y,
    output logic                              o_sat
);

    localparam int ACCW = mciir_pkg::ACCW;
    localparam int PW   = mciir_pkg::PRODW;
    localparam int SW   = mciir_pkg::SW;
    localparam int FRAC = mciir_pkg::FRAC;
    localparam int YW   = ACCW - FRAC;

    logic                    r_prod_valid;
    logic signed [PW-1:0]    r_prod;
    logic [ACCW-1:0]         r_acc;
    logic [ACCW-1:0]         rnd;
    logic [YW-1:0]           y_wide;
    logic [YW-SW:0]          y_top;
    logic                    neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_prod_valid <= 1'b0;
        else
            r_prod_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_op * i_coef;
        if (i_clear)
            r_acc <= '0;
        else if (r_prod_valid)
            r_acc <= r_acc + {{(ACCW-PW){r_prod[PW-1]}}, r_prod};
    end

    assign o_busy = r_prod_valid;

    // add half an LSB, then take the arithmetic shift as a part-select
    assign rnd    = r_acc + (ACCW'(1) << (FRAC - 1));
    assign neg    = rnd[ACCW-1];
    assign y_wide = rnd[ACCW-1:FRAC];
    assign y_top  = y_wide[YW-1:SW-1];
    assign o_sat  = !((&y_top) || (~|y_top));

    always_comb begin
        if (o_sat)
            o_y = neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            o_y = y_wide[SW-1:0];
    end

endmodule

// File: hdl/mciir_dp.sv
// ----------------------------------------------------------------------------
// mciir_dp
// Datapath: registers, coefficients, per-channel history buffers, operand
// fetch, the shared MAC and the output register.
// ----------------------------------------------------------------------------
module mciir_dp #(
    parameter int MAX_FF_TAPS  = 16,
    parameter int MAX_FB_TAPS  = 16,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mciir_pkg::t_cmd         i_cmd,
    output mciir_pkg::t_sts         o_sts,
    input  mciir_pkg::t_req_item    i_req,
    input  logic                    i_cfg_we,
    input  mciir_pkg::t_cfg_item    i_cfg,
    input  logic                    i_res_ready,
    output logic                    o_res_valid,
    output mciir_pkg::t_res_item    o_res
);

    localparam int SW   = mciir_pkg::SW;
    localparam int CW   = mciir_pkg::CW;
    localparam int TW   = mciir_pkg::TAPS_W;
    localparam int CHN  = MAX_CHANNELS;
    localparam int CHW  = (CHN > 1) ? $clog2(CHN) : 1;
    // input history keeps MAX_FF_TAPS-1 samples per channel, output history
    // MAX_FB_TAPS; a depth of one stands in where none is needed
    localparam int XD   = (MAX_FF_TAPS > 1) ? MAX_FF_TAPS - 1 : 1;
    localparam int YD   = (MAX_FB_TAPS > 0) ? MAX_FB_TAPS : 1;
    localparam int XPW  = (XD > 1) ? $clog2(XD) : 1;
    localparam int YPW  = (YD > 1) ? $clog2(YD) : 1;
    localparam int XCW  = $clog2(XD + 1);
    localparam int YCW  = $clog2(YD + 1);
    localparam int XSW  = $clog2(2 * XD + 1);
    localparam int YSW  = $clog2(2 * YD + 1);
    localparam int XAW  = (CHN * XD > 1) ? $clog2(CHN * XD) : 1;
    localparam int YAW  = (CHN * YD > 1) ? $clog2(CHN * YD) : 1;
    localparam int CFF  = (MAX_FF_TAPS < mciir_pkg::NCOEF) ? MAX_FF_TAPS : mciir_pkg::NCOEF;
    localparam int CFB  = (MAX_FB_TAPS < mciir_pkg::NCOEF) ? MAX_FB_TAPS : mciir_pkg::NCOEF;
    localparam int CFBD = (CFB > 0) ? CFB : 1;
    localparam int CFW  = (CFF > 1) ? $clog2(CFF) : 1;
    localparam int CBW  = (CFBD > 1) ? $clog2(CFBD) : 1;

    // configuration
    logic [TW-1:0]                   r_ff_taps, r_fb_taps;
    logic [mciir_pkg::NCH_W-1:0]     r_num_ch;

    // coefficients
    logic signed [CW-1:0]            r_ff_coef [CFF];
    logic signed [CW-1:0]            r_fb_coef [CFBD];

    // history ring pointers and fill counts
    logic [XPW-1:0]                  r_xwp  [CHN];
    logic [XCW-1:0]                  r_xcnt [CHN];
    logic [YPW-1:0]                  r_ywp  [CHN];
    logic [YCW-1:0]                  r_ycnt [CHN];

    logic [SW-1:0]                   xh_mem [CHN * XD];
    logic [SW-1:0]                   yh_mem [CHN * YD];
    logic [SW-1:0]                   r_xh_q, r_yh_q;

    // current sample
    logic signed [SW-1:0]            r_x;
    logic [mciir_pkg::CHAN_W-1:0]    r_ch;

    // operand stage
    logic                            r_s1_valid;
    logic signed [CW-1:0]            r_s1_coef;
    logic                            r_s1_x0, r_s1_fb, r_s1_live;

    logic                            r_out_valid;
    mciir_pkg::t_res_item            r_out;

    logic [CHW-1:0]                  ch_i;
    logic [XPW-1:0]                  xwp, x_slot;
    logic [YPW-1:0]                  ywp, y_slot;
    logic [XCW-1:0]                  xcnt;
    logic [YCW-1:0]                  ycnt;
    logic [XSW-1:0]                  x_tmp;
    logic [YSW-1:0]                  y_tmp;
    logic [XAW-1:0]                  x_rd_addr, x_wr_addr;
    logic [YAW-1:0]                  y_rd_addr, y_wr_addr;
    logic signed [CW-1:0]            ff_coef_rd, fb_coef_rd;
    logic signed [SW-1:0]            op;
    logic signed [SW-1:0]            mac_y;
    logic                            mac_sat, mac_busy;

    // ---------------- status ----------------
    always_comb begin
        o_sts.sample_ok = (32'(i_req.channel) < 32'(r_num_ch))
                       && (32'(i_req.channel) < MAX_CHANNELS);
        o_sts.nff       = (32'(r_ff_taps) > MAX_FF_TAPS) ? TW'(MAX_FF_TAPS) : r_ff_taps;
        o_sts.nfb       = (32'(r_fb_taps) > MAX_FB_TAPS) ? TW'(MAX_FB_TAPS) : r_fb_taps;
        o_sts.pipe_busy = r_s1_valid || mac_busy;
        o_sts.out_free  = !r_out_valid || i_res_ready;
    end

    // ---------------- addressing ----------------
    assign ch_i = CHW'(r_ch);
    assign xwp  = r_xwp[ch_i];
    assign ywp  = r_ywp[ch_i];
    assign xcnt = r_xcnt[ch_i];
    assign ycnt = r_ycnt[ch_i];

    // feedforward tap k reads the input of age k-1, feedback tap k the
    // output of age k; the newest entry sits just below the write pointer
    assign x_tmp  = XSW'(xwp) + XSW'(XD) - XSW'(i_cmd.tap);
    assign x_slot = (x_tmp >= XSW'(XD)) ? XPW'(x_tmp - XSW'(XD)) : XPW'(x_tmp);
    assign y_tmp  = YSW'(ywp) + YSW'(YD) - YSW'(i_cmd.tap) - YSW'(1);
    assign y_slot = (y_tmp >= YSW'(YD)) ? YPW'(y_tmp - YSW'(YD)) : YPW'(y_tmp);

    assign x_rd_addr = XAW'(ch_i) * XAW'(XD) + XAW'(x_slot);
    assign x_wr_addr = XAW'(ch_i) * XAW'(XD) + XAW'(xwp);
    assign y_rd_addr = YAW'(ch_i) * YAW'(YD) + YAW'(y_slot);
    assign y_wr_addr = YAW'(ch_i) * YAW'(YD) + YAW'(ywp);

    assign ff_coef_rd = (32'(i_cmd.tap) < CFF)  ? r_ff_coef[CFW'(i_cmd.tap)] : '0;
    assign fb_coef_rd = (32'(i_cmd.tap) < CFB)  ? r_fb_coef[CBW'(i_cmd.tap)] : '0;

    // ---------------- history memories ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_ff)
            r_xh_q <= xh_mem[x_rd_addr];
        if (i_cmd.done)
            xh_mem[x_wr_addr] <= r_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_fb)
            r_yh_q <= yh_mem[y_rd_addr];
        if (i_cmd.done)
            yh_mem[y_wr_addr] <= mac_y;
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_taps   <= TW'(1);
            r_fb_taps   <= '0;
            r_num_ch    <= mciir_pkg::NCH_W'(1);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CFF; i++)
                r_ff_coef[i] <= '0;
            for (int i = 0; i < CFBD; i++)
                r_fb_coef[i] <= '0;
            for (int i = 0; i < CHN; i++) begin
                r_xwp[i]  <= '0;
                r_xcnt[i] <= '0;
                r_ywp[i]  <= '0;
                r_ycnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg.reg_index)
                    mciir_pkg::CFG_FF_TAPS: r_ff_taps <= i_cfg.wr_data;
                    mciir_pkg::CFG_FB_TAPS: r_fb_taps <= i_cfg.wr_data;
                    mciir_pkg::CFG_NUM_CH:  r_num_ch  <= i_cfg.wr_data[mciir_pkg::NCH_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.ff_wr && (32'(i_req.coeff_index) < CFF))
                r_ff_coef[CFW'(i_req.coeff_index)] <= i_req.coeff_value;
            if (i_cmd.fb_wr && (32'(i_req.coeff_index) < CFB))
                r_fb_coef[CBW'(i_req.coeff_index)] <= i_req.coeff_value;

            if (i_cmd.clear) begin
                for (int i = 0; i < CHN; i++) begin
                    r_xcnt[i] <= '0;
                    r_ycnt[i] <= '0;
                end
            end

            if (i_cmd.done) begin
                r_xwp[ch_i]  <= (32'(xwp) == XD - 1) ? '0 : xwp + 1'b1;
                r_ywp[ch_i]  <= (32'(ywp) == YD - 1) ? '0 : ywp + 1'b1;
                if (32'(xcnt) != XD)
                    r_xcnt[ch_i] <= xcnt + 1'b1;
                if (32'(ycnt) != YD)
                    r_ycnt[ch_i] <= ycnt + 1'b1;
            end

            r_s1_valid <= i_cmd.issue_ff || i_cmd.issue_fb;

            if (i_cmd.done)
                r_out_valid <= 1'b1;
            else if (i_res_ready)
                r_out_valid <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_x  <= i_req.sample;
            r_ch <= i_req.channel;
        end
        if (i_cmd.issue_ff) begin
            r_s1_coef <= ff_coef_rd;
            r_s1_x0   <= (i_cmd.tap == '0);
            r_s1_fb   <= 1'b0;
            r_s1_live <= (32'(i_cmd.tap) <= 32'(xcnt));
        end else if (i_cmd.issue_fb) begin
            r_s1_coef <= fb_coef_rd;
            r_s1_x0   <= 1'b0;
            r_s1_fb   <= 1'b1;
            r_s1_live <= (32'(i_cmd.tap) < 32'(ycnt));
        end
        if (i_cmd.done) begin
            r_out.out_channel     <= r_ch;
            r_out.filtered_sample <= mac_y;
            r_out.saturated       <= mac_sat;
        end
    end

    // history never written since the last clear reads as zero
    always_comb begin
        if (r_s1_x0)
            op = r_x;
        else if (!r_s1_live)
            op = '0;
        else if (r_s1_fb)
            op = r_yh_q;
        else
            op = r_xh_q;
    end

    mciir_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cmd.take),
        .i_valid (r_s1_valid),
        .i_op    (op),
        .i_coef  (r_s1_coef),
        .o_busy  (mac_busy),
        .o_y     (mac_y),
        .o_sat   (mac_sat)
    );

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: hdl/multichannel_iir_filter.sv
// ----------------------------------------------------------------------------
// multichannel_iir_filter
// Direct-form-I IIR filter over up to MAX_CHANNELS interleaved channels.
//
// Channels: i_req takes requests (sample, feedforward or feedback coefficient
// write, history clear); o_res returns one filtered sample per sample request
// on a channel in use; i_cfg writes ff_taps, fb_taps and num_channels and is
// always ready. Write configuration only while no request is in flight.
// A sample runs through one shared 24x32 multiplier, one tap per cycle, and
// no new request is taken until its result is in the output register.
// The output register decouples the receiver: a stalled o_res does not block
// new requests until a second result is ready, which then waits in place.
// Reset: ff_taps = 1, fb_taps = 0, num_channels = 1, all coefficients zero,
// all history zero. History is per-channel ring storage with fill counts,
// so reset and clear act at once with no sweep.
// ----------------------------------------------------------------------------
module multichannel_iir_filter #(
    parameter int MAX_FF_TAPS  = 16,
    parameter int MAX_FB_TAPS  = 16,
    parameter int MAX_CHANNELS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mciir_stream_if.sink     i_req,
    mciir_stream_if.source   o_res,
    mciir_stream_if.sink     i_cfg
);

    mciir_pkg::t_cmd      cmd;
    mciir_pkg::t_sts      sts;
    logic                 req_ready;
    logic                 res_valid;
    mciir_pkg::t_res_item res_data;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = res_valid;
    assign o_res.data  = res_data;

    mciir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.data.req_type),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mciir_dp #(
        .MAX_FF_TAPS  (MAX_FF_TAPS),
        .MAX_FB_TAPS  (MAX_FB_TAPS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .i_res_ready (o_res.ready),
        .o_res_valid (res_valid),
        .o_res       (res_data)
    );

endmodule

// File: bench/multichannel_iir_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_iir_filter_checker
// Watches the request, result and register channels of the filter, keeps its
// own copy of coefficients, per-channel history and tap settings, works out
// the filtered sample of every accepted sample request and compares it with
// the result the filter returns, in order.
// ----------------------------------------------------------------------------
module multichannel_iir_filter_checker #(
    parameter int MAX_FF_TAPS  = 16,
    parameter int MAX_FB_TAPS  = 16,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  mciir_pkg::t_req_item i_req_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  mciir_pkg::t_res_item i_res_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  mciir_pkg::t_cfg_item i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int SW = mciir_pkg::SW;
    localparam int CW = mciir_pkg::CW;

    localparam logic signed [63:0] Y_MAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [63:0] Y_MIN = -(64'sd1 <<< (SW - 1));

    logic [mciir_pkg::TAPS_W-1:0] ff_taps_q;
    logic [mciir_pkg::TAPS_W-1:0] fb_taps_q;
    logic [mciir_pkg::NCH_W-1:0]  num_ch_q;
    logic signed [CW-1:0]         ff_coef [MAX_FF_TAPS];
    logic signed [CW-1:0]         fb_coef [MAX_FB_TAPS];
    logic signed [SW-1:0]         x_hist  [MAX_CHANNELS][MAX_FF_TAPS-1];
    logic signed [SW-1:0]         y_hist  [MAX_CHANNELS][MAX_FB_TAPS];
    mciir_pkg::t_res_item         expected_samples[$];

    task automatic report_error(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_history();
        foreach (x_hist[c, k]) x_hist[c][k] = '0;
        foreach (y_hist[c, k]) y_hist[c][k] = '0;
    endtask

    task automatic reset_state();
        ff_taps_q = mciir_pkg::TAPS_W'(1);
        fb_taps_q = '0;
        num_ch_q  = mciir_pkg::NCH_W'(1);
        foreach (ff_coef[k]) ff_coef[k] = '0;
        foreach (fb_coef[k]) fb_coef[k] = '0;
        clear_history();
        expected_samples.delete();
    endtask

    task automatic write_register(input mciir_pkg::t_cfg_item wr);
        case (wr.reg_index)
            mciir_pkg::CFG_FF_TAPS: ff_taps_q = wr.wr_data;
            mciir_pkg::CFG_FB_TAPS: fb_taps_q = wr.wr_data;
            mciir_pkg::CFG_NUM_CH:  num_ch_q  = wr.wr_data[mciir_pkg::NCH_W-1:0];
            default: ;
        endcase
    endtask

    // One sample through the filter: feedforward over the new sample and the
    // input history, feedback over the output history, round half up, clip.
    task automatic filter_sample(input mciir_pkg::t_req_item r);
        int                   nch;
        int                   nff;
        int                   nfb;
        int                   ch;
        logic signed [63:0]   acc;
        logic signed [63:0]   xs;
        logic signed [63:0]   cs;
        logic signed [63:0]   y;
        logic                 sat;
        mciir_pkg::t_res_item res;
        nch = (32'(num_ch_q) > MAX_CHANNELS) ? MAX_CHANNELS : 32'(num_ch_q);
        nff = (32'(ff_taps_q) > MAX_FF_TAPS) ? MAX_FF_TAPS : 32'(ff_taps_q);
        nfb = (32'(fb_taps_q) > MAX_FB_TAPS) ? MAX_FB_TAPS : 32'(fb_taps_q);
        ch  = 32'(r.channel);
        if (ch < nch) begin
            acc = '0;
            for (int k = 0; k < nff; k++) begin
                if (k == 0) begin
                    xs = 64'($signed(r.sample));
                end else begin
                    xs = 64'(x_hist[ch][k-1]);
                end
                cs  = 64'(ff_coef[k]);
                acc = acc + xs * cs;
            end
            for (int k = 0; k < nfb; k++) begin
                xs  = 64'(y_hist[ch][k]);
                cs  = 64'(fb_coef[k]);
                acc = acc + xs * cs;
            end
            acc = acc + (64'sd1 <<< (mciir_pkg::FRAC - 1));
            y   = acc >>> mciir_pkg::FRAC;
            sat = 1'b0;
            if (y > Y_MAX) begin
                y   = Y_MAX;
                sat = 1'b1;
            end else if (y < Y_MIN) begin
                y   = Y_MIN;
                sat = 1'b1;
            end
            // shift the full history whatever the taps in use
            for (int k = MAX_FF_TAPS - 2; k >= 1; k--) x_hist[ch][k] = x_hist[ch][k-1];
            x_hist[ch][0] = r.sample;
            for (int k = MAX_FB_TAPS - 1; k >= 1; k--) y_hist[ch][k] = y_hist[ch][k-1];
            y_hist[ch][0] = y[SW-1:0];
            res.out_channel     = r.channel;
            res.filtered_sample = y[SW-1:0];
            res.saturated       = sat;
            expected_samples.push_back(res);
        end
    endtask

    task automatic take_request(input mciir_pkg::t_req_item r);
        case (r.req_type)
            mciir_pkg::REQ_FF_WR: begin
                if (32'(r.coeff_index) < MAX_FF_TAPS)
                    ff_coef[r.coeff_index] = r.coeff_value;
            end
            mciir_pkg::REQ_FB_WR: begin
                if (32'(r.coeff_index) < MAX_FB_TAPS)
                    fb_coef[r.coeff_index] = r.coeff_value;
            end
            mciir_pkg::REQ_CLEAR:  clear_history();
            mciir_pkg::REQ_SAMPLE: filter_sample(r);
            default: ;
        endcase
    endtask

    task automatic compare_result(input mciir_pkg::t_res_item got);
        mciir_pkg::t_res_item want;
        if (expected_samples.size() == 0) begin
            report_error($sformatf("unexpected result: ch %0d y %06h sat %0b",
                got.out_channel, got.filtered_sample, got.saturated));
        end else begin
            want = expected_samples.pop_front();
            if (got.out_channel !== want.out_channel)
                report_error($sformatf("out_channel %0d, want %0d",
                    got.out_channel, want.out_channel));
            if (got.filtered_sample !== want.filtered_sample)
                report_error($sformatf("ch %0d filtered_sample %06h, want %06h",
                    want.out_channel, got.filtered_sample, want.filtered_sample));
            if (got.saturated !== want.saturated)
                report_error($sformatf("ch %0d saturated %0b, want %0b",
                    want.out_channel, got.saturated, want.saturated));
        end
    endtask

    // Results leave before new requests enter in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_data);
            if (i_res_valid && i_res_ready) compare_result(i_res_data);
            if (i_req_valid && i_req_ready) take_request(i_req_data);
        end
        o_pending <= expected_samples.size();
    end

endmodule

// File: bench/multichannel_iir_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_iir_filter_tb
// Drives sample, coefficient and clear requests into the filter in random
// bursts under several tap and channel settings, stalls the result side, and
// leaves checking to the checker module; ends with the verdict.
// ----------------------------------------------------------------------------
module multichannel_iir_filter_tb;

    localparam int MAX_FF       = 16;
    localparam int MAX_FB       = 16;
    localparam int MAX_CH       = 8;
    localparam int TARGET_ITEMS = 1300;
    localparam int HOLD_OFF     = 48;
    localparam int STALL_LIMIT  = 4000;
    localparam int SW           = mciir_pkg::SW;
    localparam int CW           = mciir_pkg::CW;
    localparam int CFG_IDX_W    = mciir_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mciir_stream_if #(.T(mciir_pkg::t_req_item)) req_if ();
    mciir_stream_if #(.T(mciir_pkg::t_res_item)) res_if ();
    mciir_stream_if #(.T(mciir_pkg::t_cfg_item)) cfg_if ();

    int pending;
    int fail_count;
    int n_items     = 0;
    int active_ch   = 1;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;
    int idle_cycles = 0;
    int rx_mode     = 0;
    int rx_mode_left = 0;
    int rx_run      = 0;
    int eff_ff;
    int eff_fb;
    int phase_len;
    int roll;

    multichannel_iir_filter #(
        .MAX_FF_TAPS  (MAX_FF),
        .MAX_FB_TAPS  (MAX_FB),
        .MAX_CHANNELS (MAX_CH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    multichannel_iir_filter_checker #(
        .MAX_FF_TAPS  (MAX_FF),
        .MAX_FB_TAPS  (MAX_FB),
        .MAX_CHANNELS (MAX_CH)
    ) filter_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_data   (res_if.data),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_data   (cfg_if.data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // Result side: a stall pattern that changes its character now and then.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(50, 400);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            2: res_if.ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_run == 0) begin
                    res_if.ready <= !res_if.ready;
                    rx_run <= res_if.ready ? $urandom_range(1, 40) : $urandom_range(1, 6);
                end else begin
                    rx_run <= rx_run - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("multichannel_iir_filter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic mciir_pkg::t_req_item make_req(input logic [1:0] kind, input int ch,
                                                      input logic [31:0] smp, input int idx,
                                                      input logic [31:0] coef);
        mciir_pkg::t_req_item r;
        r.req_type    = kind;
        r.channel     = ch[mciir_pkg::CHAN_W-1:0];
        r.sample      = smp[SW-1:0];
        r.coeff_index = idx[mciir_pkg::CIDX_W-1:0];
        r.coeff_value = coef;
        return r;
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        logic signed [SW-1:0] v;
        v = SW'($urandom);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
            1: return v >>> $urandom_range(4, 16);
            default: return v;
        endcase
    endfunction

    // Mostly modest gains so outputs stay in range, with some full-scale ones.
    function automatic logic signed [CW-1:0] rand_coeff(input bit feedback);
        logic signed [CW-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: return v;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h1000_0000;
                    default: return 32'hF000_0000;
                endcase
            end
            default: return v >>> (feedback ? $urandom_range(7, 10) : $urandom_range(3, 7));
        endcase
    endfunction

    task automatic push_request(input mciir_pkg::t_req_item item);
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (!(item.req_type == mciir_pkg::REQ_SAMPLE && 32'(item.channel) >= active_ch))
            n_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if (gaps_on) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(0, 5) == 0 ? $urandom_range(10, 45)
                                                  : $urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_index: idx, wr_data: value[mciir_pkg::CFG_DAT_W-1:0]};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    // Registers change only with the filter idle: drain, let any request with
    // no result finish, then write.
    task automatic set_config(input int ff, input int fb, input int nch);
        drain_results();
        repeat (HOLD_OFF) @(posedge i_clk);
        write_reg(mciir_pkg::CFG_FF_TAPS, ff);
        write_reg(mciir_pkg::CFG_FB_TAPS, fb);
        write_reg(mciir_pkg::CFG_NUM_CH, nch);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom_range(0, 31));
        cfg_if.valid <= 1'b0;
        active_ch = (nch % 16 > MAX_CH) ? MAX_CH : nch % 16;
        eff_ff    = (ff > MAX_FF) ? MAX_FF : ff;
        eff_fb    = (fb > MAX_FB) ? MAX_FB : fb;
    endtask

    task automatic run_directed();
        // reset settings: one feedforward tap, no feedback, one channel
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h12_3456, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 3, 32'h00_1000, 0, 0));
        push_request(make_req(mciir_pkg::REQ_FF_WR, 0, 0, 0, 32'h0000_0020));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h40_0000, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'hC0_0000, 0, 0));
        push_request(make_req(mciir_pkg::REQ_FF_WR, 0, 0, 0, 32'h1000_0000));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h7F_FFFF, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h80_0000, 0, 0));
        push_request(make_req(mciir_pkg::REQ_FF_WR, 0, 0, 0, 32'h7FFF_FFFF));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h7F_FFFF, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h80_0000, 0, 0));
        push_request(make_req(mciir_pkg::REQ_FF_WR, 0, 0, 15, 32'h8000_0000));
        push_request(make_req(mciir_pkg::REQ_FB_WR, 0, 0, 0, 32'h0800_0000));
        push_request(make_req(mciir_pkg::REQ_FB_WR, 0, 0, 15, 32'h7FFF_FFFF));
        push_request(make_req(mciir_pkg::REQ_CLEAR, 0, 0, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h60_0000, 0, 0));
        // no channels in use: samples drop
        set_config(0, 16, 0);
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h00_0100, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 5, 32'hFF_0000, 0, 0));
        // feedback only
        set_config(0, 2, 1);
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'h7F_0000, 0, 0));
        // settings above the maxima clamp; old history comes back into use
        set_config(31, 31, 15);
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 7, 32'h00_0001, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 0, 32'hFF_FFFF, 0, 0));
        push_request(make_req(mciir_pkg::REQ_SAMPLE, 3, 32'h55_AA55, 0, 0));
    endtask

    task automatic run_random();
        int ff;
        int fb;
        int nch;
        while (n_items < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0: ff = 0;
                1: ff = 1;
                2: ff = 16;
                3: ff = $urandom_range(17, 31);
                default: ff = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 9))
                0: fb = 0;
                1: fb = 16;
                2: fb = $urandom_range(17, 31);
                default: fb = $urandom_range(0, 8);
            endcase
            case ($urandom_range(0, 19))
                0: nch = 0;
                1, 2: nch = 1;
                3, 4: nch = 8;
                5, 6: nch = $urandom_range(9, 31);
                default: nch = $urandom_range(2, 8);
            endcase
            set_config(ff, fb, nch);
            gaps_on = ($urandom_range(0, 3) != 0);
            // maybe reload the filter as a whole, then maybe start from silence
            if ($urandom_range(0, 1) == 0) begin
                for (int k = 0; k < eff_ff; k++)
                    push_request(make_req(mciir_pkg::REQ_FF_WR, 0, $urandom, k,
                                          rand_coeff(1'b0)));
                for (int k = 0; k < eff_fb; k++)
                    push_request(make_req(mciir_pkg::REQ_FB_WR, 0, $urandom, k,
                                          rand_coeff(1'b1)));
            end
            if ($urandom_range(0, 3) == 0)
                push_request(make_req(mciir_pkg::REQ_CLEAR, $urandom, $urandom,
                                      $urandom, $urandom));
            phase_len = (active_ch == 0) ? 10 : $urandom_range(40, 160);
            repeat (phase_len) begin
                if ($urandom_range(0, 79) == 0) drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 82) begin
                    push_request(make_req(mciir_pkg::REQ_SAMPLE,
                        (active_ch > 0 && $urandom_range(0, 9) != 0)
                            ? $urandom_range(0, active_ch - 1) : $urandom_range(0, 7),
                        rand_sample(), $urandom, $urandom));
                end else if (roll < 90) begin
                    push_request(make_req(mciir_pkg::REQ_FF_WR, $urandom, $urandom,
                                          $urandom_range(0, 15), rand_coeff(1'b0)));
                end else if (roll < 97) begin
                    push_request(make_req(mciir_pkg::REQ_FB_WR, $urandom, $urandom,
                                          $urandom_range(0, 15), rand_coeff(1'b1)));
                end else begin
                    push_request(make_req(mciir_pkg::REQ_CLEAR, $urandom, $urandom,
                                          $urandom, $urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        drain_results();
        repeat (HOLD_OFF) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("multichannel_iir_filter regression: pass");
        end else begin
            $display("multichannel_iir_filter regression: fail");
        end
        $finish;
    end

endmodule
